// ----- rtl/bpi_pkg.sv -----
// Package for the bilinear pixel interpolator: sizes, codes, microcode and
// control types shared by the interfaces, the sequencer and the datapath.
// Depends on nothing.
package bpi_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;
   localparam int PIXEL_BITS = 16;

   // Field widths of the request and response items.
   localparam int COORD_BITS = 16;
   localparam int VALUE_BITS = 16;
   localparam int DIM_BITS   = 9;

   localparam int INT_BITS       = COORD_BITS - FRAC_BITS;
   localparam int WGT_BITS       = FRAC_BITS + 1;
   localparam int STORE_DEPTH    = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int ADDR_FULL_BITS = INT_BITS + 1 + DIM_BITS;
   localparam int ACC_BITS       = PIXEL_BITS + 2 * FRAC_BITS;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = DIM_BITS;

   localparam logic [DIM_BITS-1:0] DIM_RESET  = DIM_BITS'(256);
   localparam logic [DIM_BITS-1:0] WIDTH_CAP  = DIM_BITS'(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] HEIGHT_CAP = DIM_BITS'(MAX_HEIGHT);
   localparam logic [WGT_BITS-1:0] FRAC_ONE   = WGT_BITS'(1) << FRAC_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_BITS'(1);

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   // Microprogram step addresses, in program order.
   typedef enum logic [2:0] {
      S_IDLE,
      S_ISSUE0,
      S_ISSUE1,
      S_ISSUE2,
      S_ISSUE3,
      S_DRAIN0,
      S_DRAIN1,
      S_FINISH
   } step_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NO_REQ,
      COND_DISPATCH,
      COND_FY_ZERO,
      COND_RSP_BUSY
   } cond_type;

   // Control word as it reaches the datapath.
   typedef struct packed {
      logic       req_ready;
      logic       rd_en;
      logic [1:0] nbr;
      logic       acc_clr;
      logic       wr_en;
      logic       rsp_load;
   } ctrl_type;

   // One microcode entry: control fields plus the jump taken when cond holds.
   typedef struct packed {
      ctrl_type ctrl;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic bad;
      logic is_write;
      logic fy_zero;
      logic rsp_busy;
   } status_type;

endpackage

// ----- rtl/bpi_if.sv -----
// Handshake channels of the bilinear pixel interpolator: request, response
// and register write. Depends on bpi_pkg.
interface bpi_req_if;
   import bpi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [VALUE_BITS-1:0] pixel_value;
   modport source (output valid, kind, pos_x, pos_y, pixel_value, input ready);
   modport sink (input valid, kind, pos_x, pos_y, pixel_value, output ready);
endinterface

interface bpi_rsp_if;
   import bpi_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  out_of_range;
   modport source (output valid, value, out_of_range, input ready);
   modport sink (input valid, value, out_of_range, output ready);
endinterface

interface bpi_csr_if;
   import bpi_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/bpi_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
module bpi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/bpi_useq.sv -----
// Microcoded sequencer: step counter, control-store ROM and jump logic.
// Depends on bpi_pkg.
module bpi_useq (
   input  logic                clock,
   input  logic                reset,
   input  bpi_pkg::status_type status,
   output bpi_pkg::ctrl_type   ctrl
);
   import bpi_pkg::*;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      unique case (step)
         S_IDLE: begin
            w.ctrl.req_ready = 1'b1;
            w.cond           = COND_NO_REQ;
            w.target         = S_IDLE;
         end
         S_ISSUE0: begin
            w.ctrl.rd_en   = 1'b1;
            w.ctrl.nbr     = 2'd0;
            w.ctrl.acc_clr = 1'b1;
            w.ctrl.wr_en   = 1'b1;
            w.cond         = COND_DISPATCH;
            w.target       = S_IDLE;
         end
         S_ISSUE1: begin
            w.ctrl.rd_en = 1'b1;
            w.ctrl.nbr   = 2'd1;
            w.cond       = COND_FY_ZERO;
            w.target     = S_DRAIN0;
         end
         S_ISSUE2: begin
            w.ctrl.rd_en = 1'b1;
            w.ctrl.nbr   = 2'd2;
         end
         S_ISSUE3: begin
            w.ctrl.rd_en = 1'b1;
            w.ctrl.nbr   = 2'd3;
         end
         S_DRAIN0: begin
            w.cond = COND_NONE;
         end
         S_DRAIN1: begin
            w.cond = COND_NONE;
         end
         S_FINISH: begin
            w.ctrl.rsp_load = 1'b1;
            w.cond          = COND_RSP_BUSY;
            w.target        = S_FINISH;
         end
      endcase
      return w;
   endfunction

   step_type  pc_ff;
   step_type  pc_in;
   ucode_type word;
   logic      cond_true;
   logic [2:0] pc_inc;

   assign word   = ucode_rom(pc_ff);
   assign pc_inc = pc_ff + 3'd1;

   always_comb begin
      unique case (word.cond)
         COND_NONE:     cond_true = 1'b0;
         COND_NO_REQ:   cond_true = status.no_req;
         COND_DISPATCH: cond_true = status.bad | status.is_write;
         COND_FY_ZERO:  cond_true = status.fy_zero;
         COND_RSP_BUSY: cond_true = status.rsp_busy;
         default:       cond_true = 1'b0;
      endcase
   end

   // Next step. The dispatch jump sends a rejected item to the response
   // step and a finished pixel write back to idle.
   always_comb begin
      if (!cond_true) begin
         pc_in = step_type'(pc_inc);
      end else if (word.cond == COND_DISPATCH) begin
         pc_in = status.bad ? S_FINISH : S_IDLE;
      end else begin
         pc_in = word.target;
      end
   end

   always_comb begin
      ctrl          = word.ctrl;
      ctrl.rsp_load = word.ctrl.rsp_load & ~cond_true;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (ctrl.req_ready && !status.no_req) |=> (pc_ff == S_ISSUE0))
      else $error("accepted request did not start the program");

   a_finish_returns: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == S_FINISH && !status.rsp_busy) |=> (pc_ff == S_IDLE))
      else $error("finish step did not return to idle");

endmodule

// ----- rtl/bpi_dpath.sv -----
// Datapath: request and register holding, address and weight generation,
// pixel store, multiply-accumulate pipeline and response register.
// Depends on bpi_pkg and bpi_ram.
module bpi_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bpi_pkg::ctrl_type                    ctrl,
   output bpi_pkg::status_type                  status,
   input  logic                                 req_valid,
   input  logic                                 req_kind,
   input  logic [bpi_pkg::COORD_BITS-1:0]       req_pos_x,
   input  logic [bpi_pkg::COORD_BITS-1:0]       req_pos_y,
   input  logic [bpi_pkg::VALUE_BITS-1:0]       req_pixel_value,
   input  logic                                 csr_valid,
   input  logic [bpi_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bpi_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [bpi_pkg::VALUE_BITS-1:0]       rsp_value,
   output logic                                 rsp_out_of_range
);
   import bpi_pkg::*;

   kind_type              kind_ff;
   logic [COORD_BITS-1:0] px_ff;
   logic [COORD_BITS-1:0] py_ff;
   logic [VALUE_BITS-1:0] pv_ff;
   logic [DIM_BITS-1:0]   width_ff;
   logic [DIM_BITS-1:0]   height_ff;

   logic [INT_BITS-1:0]  ix;
   logic [INT_BITS-1:0]  iy;
   logic [FRAC_BITS-1:0] fx;
   logic [FRAC_BITS-1:0] fy;
   logic [DIM_BITS-1:0]  eff_w;
   logic [DIM_BITS-1:0]  eff_h;
   logic [INT_BITS:0]    xe;
   logic [INT_BITS:0]    ye;
   logic                 bad;

   logic                      dx;
   logic                      dy;
   logic [INT_BITS:0]         x_sel;
   logic [INT_BITS:0]         y_sel;
   logic [ADDR_FULL_BITS-1:0] addr_full;
   logic [WGT_BITS-1:0]       wx;
   logic [WGT_BITS-1:0]       wy;
   logic [2*WGT_BITS-1:0]     wgt_in;
   logic                      rd_gate;
   logic                      wr_gate;

   logic [PIXEL_BITS-1:0]            ram_rdata;
   logic [2*WGT_BITS-1:0]            wgt_ff;
   logic                             p1_ff;
   logic                             p2_ff;
   logic [PIXEL_BITS+2*WGT_BITS-1:0] mul_full;
   logic [ACC_BITS-1:0]              prod_ff;
   logic [ACC_BITS-1:0]              acc_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (req_valid && ctrl.req_ready) begin
         kind_ff <= kind_type'(req_kind);
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         pv_ff   <= req_pixel_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign ix    = px_ff[COORD_BITS-1:FRAC_BITS];
   assign iy    = py_ff[COORD_BITS-1:FRAC_BITS];
   assign fx    = px_ff[FRAC_BITS-1:0];
   assign fy    = py_ff[FRAC_BITS-1:0];
   assign eff_w = (width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff;
   assign eff_h = (height_ff > HEIGHT_CAP) ? HEIGHT_CAP : height_ff;

   // A query also needs the right and lower neighbors when their weight
   // is nonzero, so its far edge is checked instead of its base pixel.
   assign xe = {1'b0, ix} + (INT_BITS+1)'(fx != '0);
   assign ye = {1'b0, iy} + (INT_BITS+1)'(fy != '0);

   always_comb begin
      if (kind_ff == KIND_QUERY) begin
         bad = (xe >= eff_w) || (ye >= eff_h);
      end else begin
         bad = ({1'b0, ix} >= eff_w) || ({1'b0, iy} >= eff_h);
      end
   end

   assign dx        = ctrl.nbr[0];
   assign dy        = ctrl.nbr[1];
   assign x_sel     = {1'b0, ix} + (INT_BITS+1)'(dx);
   assign y_sel     = {1'b0, iy} + (INT_BITS+1)'(dy);
   assign addr_full = ADDR_FULL_BITS'(y_sel) * ADDR_FULL_BITS'(eff_w)
                    + ADDR_FULL_BITS'(x_sel);

   assign wx     = dx ? {1'b0, fx} : (FRAC_ONE - {1'b0, fx});
   assign wy     = dy ? {1'b0, fy} : (FRAC_ONE - {1'b0, fy});
   assign wgt_in = (2*WGT_BITS)'(wx) * (2*WGT_BITS)'(wy);

   assign rd_gate = ctrl.rd_en && (kind_ff == KIND_QUERY) && !bad && (wgt_in != '0);
   assign wr_gate = ctrl.wr_en && (kind_ff == KIND_WRITE) && !bad;

   bpi_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (rd_gate | wr_gate),
      .we    (wr_gate),
      .addr  (ADDR_BITS'(addr_full)),
      .wdata (pv_ff[PIXEL_BITS-1:0]),
      .rdata (ram_rdata)
   );

   // Read data and its weight are both registered when the read is issued and
   // meet in the cycle after; the product is registered before it reaches the accumulator.
   assign mul_full = (PIXEL_BITS+2*WGT_BITS)'(ram_rdata)
                   * (PIXEL_BITS+2*WGT_BITS)'(wgt_ff);

   always_ff @(posedge clock) begin
      if (rd_gate) begin
         wgt_ff <= wgt_in;
      end
      prod_ff <= mul_full[ACC_BITS-1:0];
      if (ctrl.acc_clr) begin
         acc_ff <= '0;
      end else if (p2_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff <= 1'b0;
         p2_ff <= 1'b0;
      end else begin
         p1_ff <= rd_gate;
         p2_ff <= p1_ff;
      end
   end

   assign rsp_valid_in = ctrl.rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_load) begin
         rsp_value_ff <= bad ? '0 : acc_ff[ACC_BITS-1 -: VALUE_BITS];
         rsp_oor_ff   <= bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   assign status.no_req   = ~req_valid;
   assign status.bad      = bad;
   assign status.is_write = (kind_ff == KIND_WRITE);
   assign status.fy_zero  = (fy == '0);
   assign status.rsp_busy = rsp_valid_ff & ~rsp_ready;

   a_clear_idle_pipe: assert property (@(posedge clock) disable iff (reset)
      ctrl.acc_clr |-> !p2_ff)
      else $error("accumulator cleared while a product was arriving");

   a_load_after_drain: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!p1_ff && !p2_ff))
      else $error("response loaded before the multiply pipeline drained");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten while still held");

endmodule

// ----- rtl/bilinear_pixel_interpolator.sv -----
// Top level of the bilinear pixel interpolator: ties the microcoded
// sequencer to the datapath and the channel interfaces.
// Depends on bpi_pkg, bpi_if, bpi_useq and bpi_dpath.
//
// Usage: req_bus carries one request per valid/ready handshake. A write
// request (kind 0) stores pixel_value at the integer part of (pos_x, pos_y);
// a query (kind 1) returns the bilinear blend of up to four neighbors at a
// point with 8 fraction bits, truncated. Each query and each rejected write
// produces one response on rsp_bus; a write inside the image produces none.
// csr_bus writes image_width (index 0) and image_height (index 1); it is
// always ready and must only be used while no request is in flight.
// Timing: a request is accepted only while the sequencer sits at its idle
// step. A write inside the image runs the first issue step and returns to
// idle; a rejected item goes on to the finish step; a query issues two
// neighbor reads when its y fraction is zero and four otherwise, then
// passes both drain steps to the finish step, which loads the response,
// presented on the next cycle. The program follows the single-port pixel
// memory, one neighbor read per cycle, and the two-stage multiply-accumulate.
// The response register lets the next request be accepted while a response
// waits; a stalled receiver holds the program at its finish step only when
// a second response is ready. Reset returns the sequencer to idle, drops
// any held response and sets both dimensions to 256; pixel contents are
// not cleared and must be written before they are read.
module bilinear_pixel_interpolator (
   input logic       clock,
   input logic       reset,
   bpi_req_if.sink   req_bus,
   bpi_rsp_if.source rsp_bus,
   bpi_csr_if.sink   csr_bus
);
   import bpi_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   bpi_useq u_useq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   bpi_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_valid        (req_bus.valid),
      .req_kind         (req_bus.kind),
      .req_pos_x        (req_bus.pos_x),
      .req_pos_y        (req_bus.pos_y),
      .req_pixel_value  (req_bus.pixel_value),
      .csr_valid        (csr_bus.valid),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_value        (rsp_bus.value),
      .rsp_out_of_range (rsp_bus.out_of_range)
   );

   assign req_bus.ready = ctrl.req_ready;
   assign csr_bus.ready = 1'b1;

endmodule

// ----- dv/tb_bilinear_pixel_interpolator.sv -----
`timescale 1ns / 100ps
// Testbench for the bilinear pixel interpolator: drives pixel writes, queries and
// register writes, predicts every response from a shadow image and checks it.
// Depends on bpi_pkg, bpi_if and bilinear_pixel_interpolator.
module tb_bilinear_pixel_interpolator;
   import bpi_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_WAIT     = 17;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 85;
   localparam int REBASE_ITEMS = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int WINDOW_SPAN  = 5;
   localparam int COORD_MAX    = (1 << INT_BITS) - 1;
   localparam longint unsigned FRAC_SCALE = longint'(1) << FRAC_BITS;

   // Indexes that decode to no register; writes to them must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LAST_INDEX  = '1;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  out_of_range;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpi_req_if req_if ();
   bpi_rsp_if rsp_if ();
   bpi_csr_if csr_if ();

   bilinear_pixel_interpolator i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   bit [PIXEL_BITS-1:0] shadow_image [STORE_DEPTH];
   bit                  shadow_written [STORE_DEPTH];
   logic [DIM_BITS-1:0] shadow_width  = DIM_RESET;
   logic [DIM_BITS-1:0] shadow_height = DIM_RESET;
   pixel_result_type    expected_pixels [$];
   int                  mismatch_count = 0;
   int unsigned         cycle_count = 0;
   bit                  steady_flow = 1'b0;
   int                  hold_off_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int unsigned active_dim(input logic [DIM_BITS-1:0] dim, input int cap);
      return (dim > cap) ? cap : dim;
   endfunction

   function automatic longint unsigned stored_pixel(input int unsigned x, y, w);
      int unsigned idx;
      idx = y * w + x;
      return (idx < STORE_DEPTH) ? longint'(shadow_image[idx]) : 0;
   endfunction

   // Writes update the shadow image; returns 1 when the request yields a response.
   function automatic bit predict_pixel_result(input kind_type kind,
                                               input logic [COORD_BITS-1:0] px, py,
                                               input logic [VALUE_BITS-1:0] pv,
                                               output pixel_result_type res);
      int unsigned ix, iy, fx, fy, w, h, idx;
      longint unsigned acc;
      ix = px[COORD_BITS-1:FRAC_BITS];
      iy = py[COORD_BITS-1:FRAC_BITS];
      fx = px[FRAC_BITS-1:0];
      fy = py[FRAC_BITS-1:0];
      w = active_dim(shadow_width, MAX_WIDTH);
      h = active_dim(shadow_height, MAX_HEIGHT);
      res.value = '0;
      res.out_of_range = 1'b1;
      if (kind == KIND_WRITE) begin
         if (ix >= w || iy >= h) return 1'b1;
         idx = iy * w + ix;
         shadow_image[idx] = pv;
         shadow_written[idx] = 1'b1;
         return 1'b0;
      end
      // A neighbor with zero weight is neither range checked nor counted.
      if (ix + (fx != 0 ? 1 : 0) >= w || iy + (fy != 0 ? 1 : 0) >= h) return 1'b1;
      acc = stored_pixel(ix, iy, w) * ((FRAC_SCALE - fx) * (FRAC_SCALE - fy))
          + stored_pixel(ix + 1, iy, w) * (longint'(fx) * (FRAC_SCALE - fy))
          + stored_pixel(ix, iy + 1, w) * ((FRAC_SCALE - fx) * longint'(fy))
          + stored_pixel(ix + 1, iy + 1, w) * (longint'(fx) * longint'(fy));
      res.value = VALUE_BITS'(acc >> (2 * FRAC_BITS));
      res.out_of_range = 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [COORD_BITS-1:0] fixed_pos(input int ipart, input int frac);
      return {INT_BITS'(ipart), FRAC_BITS'(frac)};
   endfunction

   function automatic int unsigned random_frac();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return $urandom_range(0, 1) ? int'(FRAC_SCALE - 1) : 1;
         default: return $urandom_range(1, int'(FRAC_SCALE - 1));
      endcase
   endfunction

   task automatic send_request(input kind_type kind, input logic [COORD_BITS-1:0] px, py,
                               input logic [VALUE_BITS-1:0] pv);
      int gap;
      pixel_result_type res;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.kind        <= kind;
      req_if.pos_x       <= px;
      req_if.pos_y       <= py;
      req_if.pixel_value <= pv;
      do @(posedge clock); while (!req_if.ready);
      if (predict_pixel_result(kind, px, py, pv, res)) expected_pixels.push_back(res);
   endtask

   // Every neighbor that a query weighs must hold a written pixel, so missing
   // ones are written first.
   task automatic send_query(input logic [COORD_BITS-1:0] px, py);
      int unsigned ix, iy, xs, ys, w, h;
      ix = px[COORD_BITS-1:FRAC_BITS];
      iy = py[COORD_BITS-1:FRAC_BITS];
      xs = (px[FRAC_BITS-1:0] != 0) ? 1 : 0;
      ys = (py[FRAC_BITS-1:0] != 0) ? 1 : 0;
      w = active_dim(shadow_width, MAX_WIDTH);
      h = active_dim(shadow_height, MAX_HEIGHT);
      if (ix + xs < w && iy + ys < h) begin
         for (int unsigned dy = 0; dy <= ys; dy++) begin
            for (int unsigned dx = 0; dx <= xs; dx++) begin
               if (!shadow_written[(iy + dy) * w + ix + dx])
                  send_request(KIND_WRITE, fixed_pos(ix + dx, $urandom),
                               fixed_pos(iy + dy, $urandom), VALUE_BITS'($urandom));
            end
         end
      end
      send_request(KIND_QUERY, px, py, VALUE_BITS'($urandom));
   endtask

   // Waits until every response has arrived and the block has gone quiet.
   task automatic drain_block();
      req_if.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [DIM_BITS-1:0] data);
      drain_block();
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) shadow_width = data;
      else if (index == CSR_IMAGE_HEIGHT) shadow_height = data;
   endtask

   task automatic set_image_size(input int w, input int h);
      write_register(CSR_IMAGE_WIDTH, DIM_BITS'(w));
      write_register(CSR_IMAGE_HEIGHT, DIM_BITS'(h));
   endtask

   task automatic test_directed_items();
      set_image_size(3, 2);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(0, 0), 16'hFFFF);
      send_request(KIND_WRITE, fixed_pos(1, 255), fixed_pos(0, 255), 16'h0000);
      send_request(KIND_WRITE, fixed_pos(2, 0), fixed_pos(0, 0), 16'h8001);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(1, 0), 16'hFFFF);
      send_request(KIND_WRITE, fixed_pos(1, 0), fixed_pos(1, 0), 16'h1234);
      send_request(KIND_WRITE, fixed_pos(2, 0), fixed_pos(1, 0), 16'h7FFF);
      // Writes just past the right and bottom edges, and at the largest position.
      send_request(KIND_WRITE, fixed_pos(3, 0), fixed_pos(0, 0), 16'hAAAA);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(2, 0), 16'h5555);
      send_request(KIND_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_query(fixed_pos(0, 0), fixed_pos(0, 0));
      send_query(fixed_pos(2, 0), fixed_pos(1, 0));
      send_query(fixed_pos(0, 128), fixed_pos(0, 0));
      send_query(fixed_pos(1, 0), fixed_pos(0, 255));
      send_query(fixed_pos(0, 255), fixed_pos(0, 255));
      send_query(fixed_pos(1, 1), fixed_pos(0, 1));
      // On the last column a zero x fraction keeps the query inside the image.
      send_query(fixed_pos(2, 0), fixed_pos(0, 77));
      send_query(fixed_pos(2, 1), fixed_pos(0, 0));
      send_query(fixed_pos(0, 0), fixed_pos(1, 1));
      send_query(16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_register_extremes();
      set_image_size(0, 256);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(0, 0), 16'h1111);
      send_query(fixed_pos(0, 0), fixed_pos(0, 0));
      set_image_size(256, 0);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(0, 0), 16'h2222);
      send_query(fixed_pos(0, 0), fixed_pos(0, 0));
      // Values above the maximum behave as the maximum.
      set_image_size(511, 511);
      send_request(KIND_WRITE, fixed_pos(255, 0), fixed_pos(255, 0), 16'hC3A5);
      send_query(fixed_pos(255, 0), fixed_pos(255, 0));
      send_query(fixed_pos(255, 1), fixed_pos(255, 0));
      send_query(fixed_pos(255, 0), fixed_pos(254, 128));
      set_image_size(257, 300);
      send_query(fixed_pos(255, 0), fixed_pos(255, 0));
      send_query(fixed_pos(254, 200), fixed_pos(255, 0));
      set_image_size(1, 1);
      send_request(KIND_WRITE, fixed_pos(0, 0), fixed_pos(0, 0), 16'h8000);
      send_query(fixed_pos(0, 0), fixed_pos(0, 0));
      send_query(fixed_pos(0, 1), fixed_pos(0, 0));
      send_query(fixed_pos(0, 0), fixed_pos(0, 255));
      send_request(KIND_WRITE, fixed_pos(1, 0), fixed_pos(0, 0), 16'h0001);
      write_register(CSR_SPARE_INDEX, DIM_BITS'(5));
      write_register(CSR_LAST_INDEX, '1);
      send_query(fixed_pos(0, 0), fixed_pos(0, 0));
      send_query(fixed_pos(1, 0), fixed_pos(0, 0));
   endtask

   // Pixels stay where they are when the width changes and are read with the new stride.
   task automatic test_stride_change();
      set_image_size(4, 2);
      for (int y = 0; y < 2; y++)
         for (int x = 0; x < 4; x++)
            send_request(KIND_WRITE, fixed_pos(x, 0), fixed_pos(y, 0), VALUE_BITS'($urandom));
      set_image_size(2, 4);
      for (int i = 0; i < 8; i++)
         send_query(fixed_pos($urandom_range(0, 1), random_frac()),
                    fixed_pos($urandom_range(0, 3), random_frac()));
   endtask

   task automatic test_backpressure();
      set_image_size(4, 4);
      steady_flow = 1'b1;
      hold_off_cycles = HOLD_CYCLES;
      for (int i = 0; i < 24; i++)
         send_query(fixed_pos($urandom_range(0, 3), random_frac()),
                    fixed_pos($urandom_range(0, 3), random_frac()));
      steady_flow = 1'b0;
   endtask

   task automatic run_random_phase(input int w_reg, input int h_reg, input bit steady);
      int unsigned w, h, x0, y0, span_x, span_y, ix, iy, pick;
      set_image_size(w_reg, h_reg);
      steady_flow = steady;
      w = active_dim(shadow_width, MAX_WIDTH);
      h = active_dim(shadow_height, MAX_HEIGHT);
      span_x = (w > WINDOW_SPAN) ? WINDOW_SPAN : w;
      span_y = (h > WINDOW_SPAN) ? WINDOW_SPAN : h;
      x0 = 0;
      y0 = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // Work in a small window so that few pixels need writing before a read.
         if (i % REBASE_ITEMS == 0) begin
            x0 = (w > WINDOW_SPAN) ? $urandom_range(0, w - WINDOW_SPAN) : 0;
            y0 = (h > WINDOW_SPAN) ? $urandom_range(0, h - WINDOW_SPAN) : 0;
         end
         ix = x0 + $urandom_range(0, span_x);
         iy = y0 + $urandom_range(0, span_y);
         if (ix > COORD_MAX) ix = COORD_MAX;
         if (iy > COORD_MAX) iy = COORD_MAX;
         pick = $urandom_range(0, 99);
         if (pick < 15)
            send_request(KIND_WRITE, fixed_pos(ix, $urandom), fixed_pos(iy, $urandom),
                         VALUE_BITS'($urandom));
         else if (pick < 20)
            send_request(KIND_WRITE, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         VALUE_BITS'($urandom));
         else if (pick < 27)
            send_query(COORD_BITS'($urandom), COORD_BITS'($urandom));
         else
            send_query(fixed_pos(ix, random_frac()), fixed_pos(iy, random_frac()));
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_phases();
      int phase_w [12];
      int phase_h [12];
      phase_w = '{1, 2, 256, 511, 1, 256, 0, 7, 3, 16, 0, 0};
      phase_h = '{1, 2, 256, 511, 256, 1, 7, 0, 5, 16, 0, 0};
      phase_w[10] = $urandom_range(1, 64);
      phase_h[10] = $urandom_range(1, 64);
      phase_w[11] = $urandom_range(1, 511);
      phase_h[11] = $urandom_range(1, 12);
      for (int p = 0; p < 12; p++)
         run_random_phase(phase_w[p], phase_h[p], (p % 4) == 3);
   endtask

   always @(posedge clock) begin : check_responses
      pixel_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response, expected none, actual value %h out_of_range %b",
                     $time, rsp_if.value, rsp_if.out_of_range);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_if.value !== want.value) begin
               mismatch_count++;
               $display("%0t: value mismatch, expected %h, actual %h",
                        $time, want.value, rsp_if.value);
            end
            if (rsp_if.out_of_range !== want.out_of_range) begin
               mismatch_count++;
               $display("%0t: out_of_range mismatch, expected %b, actual %b",
                        $time, want.out_of_range, rsp_if.out_of_range);
            end
         end
      end
   end

   // The receiver stalls for a random count before each response (no stall in
   // steady flow), or for a long hold-off when one is requested.
   initial begin : drive_rsp_ready
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   initial begin
      req_if.valid       <= 1'b0;
      req_if.kind        <= KIND_WRITE;
      req_if.pos_x       <= '0;
      req_if.pos_y       <= '0;
      req_if.pixel_value <= '0;
      csr_if.valid       <= 1'b0;
      csr_if.index       <= '0;
      csr_if.data        <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_items();
      test_register_extremes();
      test_stride_change();
      test_backpressure();
      test_random_phases();
      drain_block();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
